// ===== rtl/core/pcsatlb_pkg.sv =====
// Shared types and constants for the per-CPU set-associative LRU TLB.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package pcsatlb_pkg;

   // NUM_SETS is a power of two; the set is the low bits of the page number.
   localparam int NUM_CPUS = 4;
   localparam int NUM_SETS = 512;
   localparam int NUM_WAYS = 4;

   localparam int ROWS  = NUM_CPUS * NUM_SETS;
   localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_PROBE  = 1'b1;

   typedef struct packed {
      logic [63:0] page;
      logic [63:0] stamp;
   } way_type;

   typedef struct packed {
      logic [NUM_WAYS-1:0]          valid;
      way_type [NUM_WAYS-1:0]       way;
   } row_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_EVICT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic start;
      logic probe_next;
      logic finish_access;
      logic evict_init;
      logic evict_step;
      logic finish_evict;
      logic finish_probe;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_probe;
      logic hit;
      logic have_free;
      logic probe_last;
      logic evict_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/pcsatlb_ctrl.sv =====
// Controller state machine for the TLB: sequences clearing, lookup, eviction and response.
// Depends on pcsatlb_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none

module pcsatlb_ctrl
   import pcsatlb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (status.is_probe) begin
               if ((status.hit || status.probe_last) && status.out_free) state_in = ST_IDLE;
            end else if (status.hit || status.have_free) begin
               if (status.out_free) state_in = ST_IDLE;
            end else if (NUM_WAYS > 1) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_EVICT: begin
            if (status.evict_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_LOOK: begin
            if (status.is_probe) begin
               if (status.hit || status.probe_last) begin
                  cmd.finish_probe = status.out_free;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end else if (status.hit || status.have_free) begin
               cmd.finish_access = status.out_free;
            end else begin
               cmd.evict_init = 1'b1;
            end
         end
         ST_EVICT: begin
            cmd.evict_step = 1'b1;
         end
         ST_WRITE: begin
            cmd.finish_evict = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcsatlb_dpath.sv =====
// Datapath for the TLB: set memory, per-CPU stamp counters, way compare, victim search, response register.
// Depends on pcsatlb_pkg; controlled by pcsatlb_ctrl through ctrl_cmd_type.
`default_nettype none

module pcsatlb_dpath
   import pcsatlb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_cmd,
   input  wire logic [7:0]    req_cpu_num,
   input  wire logic [63:0]   req_page_number,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_found
);

   function automatic logic [ROW_W-1:0] row_of(input logic [CPU_W-1:0] cpu,
                                               input logic [63:0] page);
      logic [SET_W-1:0] set;
      set = page[SET_W-1:0] & SET_W'(NUM_SETS - 1);
      return ROW_W'(ROW_W'(cpu) * ROW_W'(NUM_SETS)) + ROW_W'(set);
   endfunction

   row_type mem [ROWS];

   row_type            rd_row_ff;
   logic [ROW_W-1:0]   addr_ff;
   logic [63:0]        page_ff;
   logic               cmd_ff;
   logic [CPU_W-1:0]   cpu_ff;
   logic [ROW_W-1:0]   clr_cnt_ff;
   logic [63:0]        clk_ff [NUM_CPUS];
   logic [WAY_W-1:0]   victim_ff;
   logic [WAY_W-1:0]   evict_cnt_ff;
   logic [63:0]        min_stamp_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;

   logic [CPU_W-1:0]   sel_cpu;
   logic [CPU_W-1:0]   start_cpu;
   logic [CPU_W-1:0]   next_cpu;
   logic [ROW_W-1:0]   rd_addr_in;
   logic               rd_en;
   logic [NUM_WAYS-1:0] match;
   logic               hit;
   logic [WAY_W-1:0]   hit_way;
   logic [WAY_W-1:0]   free_way;
   logic [WAY_W-1:0]   fill_way;
   row_type            wr_row_in;
   logic [ROW_W-1:0]   wr_addr_in;
   logic               wr_en;
   logic               finish;
   logic               fill;

   assign sel_cpu   = (req_cpu_num < 8'(NUM_CPUS)) ? req_cpu_num[CPU_W-1:0] : '0;
   assign start_cpu = (req_cmd == CMD_PROBE) ? '0 : sel_cpu;
   assign next_cpu  = cpu_ff + CPU_W'(1);
   assign rd_en     = cmd.start | cmd.probe_next;
   assign rd_addr_in = cmd.start ? row_of(start_cpu, req_page_number)
                                 : row_of(next_cpu, page_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr_in];
         addr_ff   <= rd_addr_in;
      end
      if (wr_en) begin
         mem[wr_addr_in] <= wr_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff <= req_page_number;
         cmd_ff  <= req_cmd;
         cpu_ff  <= start_cpu;
      end else if (cmd.probe_next) begin
         cpu_ff <= next_cpu;
      end
   end

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         match[w] = rd_row_ff.valid[w] && (rd_row_ff.way[w].page == page_ff);
         if (match[w]) hit_way = WAY_W'(w);
         if (!rd_row_ff.valid[w]) free_way = WAY_W'(w);
      end
      hit = |match;
   end

   assign fill     = cmd.finish_access | cmd.finish_evict;
   assign finish   = fill | cmd.finish_probe;
   assign fill_way = cmd.finish_evict ? victim_ff : (hit ? hit_way : free_way);
   assign wr_en    = cmd.clr_step | fill;
   assign wr_addr_in = cmd.clr_step ? clr_cnt_ff : addr_ff;

   always_comb begin
      wr_row_in = rd_row_ff;
      if (cmd.clr_step) begin
         wr_row_in = '0;
      end else begin
         wr_row_in.valid[fill_way]     = 1'b1;
         wr_row_in.way[fill_way].page  = page_ff;
         wr_row_in.way[fill_way].stamp = clk_ff[cpu_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            clk_ff[c] <= '0;
         end
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + ROW_W'(1);
         if (fill) clk_ff[cpu_ff] <= clk_ff[cpu_ff] + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evict_init) begin
         victim_ff    <= '0;
         min_stamp_ff <= rd_row_ff.way[0].stamp;
         evict_cnt_ff <= WAY_W'(1);
      end else if (cmd.evict_step) begin
         if (rd_row_ff.way[evict_cnt_ff].stamp < min_stamp_ff) begin
            victim_ff    <= evict_cnt_ff;
            min_stamp_ff <= rd_row_ff.way[evict_cnt_ff].stamp;
         end
         evict_cnt_ff <= evict_cnt_ff + WAY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) rsp_found_ff <= cmd.finish_evict ? 1'b0 : hit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   assign status.clr_last   = (clr_cnt_ff == ROW_W'(ROWS - 1));
   assign status.is_probe   = (cmd_ff == CMD_PROBE);
   assign status.hit        = hit;
   assign status.have_free  = ~&rd_row_ff.valid;
   assign status.probe_last = (cpu_ff == CPU_W'(NUM_CPUS - 1));
   assign status.evict_last = (evict_cnt_ff == WAY_W'(NUM_WAYS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   a_finish_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.finish_access, cmd.finish_evict, cmd.finish_probe}))
      else $error("more than one finish command in a cycle");

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response written while a previous one is pending");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("memory read and write issued together");

   a_finish_resp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished request produced no response");

endmodule

`default_nettype wire

// ===== rtl/core/per_cpu_set_assoc_lru_tlb_unit.sv =====
// Top level of the per-CPU set-associative LRU TLB: controller plus datapath.
// Depends on pcsatlb_pkg, pcsatlb_ctrl and pcsatlb_dpath.
//
// A request carries cmd, cpu_num and page_number; each request yields one
// response with found. An access (cmd 0) looks the page up in its CPU's set,
// refreshes the stamp on a hit and fills the first free or oldest way on a
// miss. A probe (cmd 1) checks the page in every CPU's TLB and changes nothing.
// Both channels use valid/ready handshakes.
// An access that hits or finds a free way goes from the lookup straight to the
// response; a miss into a full set first runs a victim search that steps
// through the ways one per cycle. A probe reads the CPU sets one per cycle
// from the set memory until it hits or has read the set of every CPU.
// One request is in progress at a time; the next request may be accepted while
// the previous response still waits in the output register. When the receiver
// stalls, the block holds its final write until the output register is free.
// After reset all NUM_CPUS * NUM_SETS rows (2048) of the set memory are cleared
// one row per cycle, with req_ready low during that pass.
`default_nettype none

module per_cpu_set_assoc_lru_tlb_unit
   import pcsatlb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_cpu_num,
   input  wire logic [63:0] req_page_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pcsatlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcsatlb_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_cpu_num     (req_cpu_num),
      .req_page_number (req_page_number),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found)
   );

endmodule

`default_nettype wire

// ===== dv/tb_per_cpu_set_assoc_lru_tlb_unit.sv =====
// Testbench for the per-CPU set-associative LRU TLB: directed and random requests,
// with a built-in predictor of hits, fills, evictions and probes.
// Depends on pcsatlb_pkg and per_cpu_set_assoc_lru_tlb_unit.
`default_nettype none

module tb_per_cpu_set_assoc_lru_tlb_unit;
   import pcsatlb_pkg::*;

   localparam int DEPTH         = NUM_CPUS * NUM_SETS * NUM_WAYS;
   localparam int STALL_LIMIT   = 10000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_PERCENT  = 16;

   typedef struct {
      logic        cmd;
      logic [7:0]  cpu_num;
      logic [63:0] page;
      logic        found;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_ACCESS;
   logic [7:0]  req_cpu_num = 8'd0;
   logic [63:0] req_page_number = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;

   // Predicted TLB contents and per-CPU stamp counters.
   bit          tlb_valid [DEPTH];
   logic [63:0] tlb_page  [DEPTH];
   logic [63:0] tlb_stamp [DEPTH];
   logic [63:0] cpu_tick  [NUM_CPUS];

   pending_type pending_found[$];
   pending_type oldest;

   int          mismatches = 0;
   int          stall_cycles = 0;
   int          n_access = 0;
   int          n_probe = 0;
   int          n_hit = 0;
   int          n_evict = 0;
   int          n_foreign_cpu = 0;
   bit          no_idle = 1'b0;
   int          hold_asked = 0;
   int          hold_done = 0;
   int          hold_count = 0;
   int          hot_set [6];
   logic [63:0] hot_tag [8];

   per_cpu_set_assoc_lru_tlb_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_cpu_num     (req_cpu_num),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found)
   );

   always #10 clock = ~clock;

   function automatic logic predict_found(input logic cmd, input logic [7:0] cpu_raw,
                                          input logic [63:0] page);
      int   cpu;
      int   base;
      int   way;
      int   w;
      int   c;
      bit   have_free;
      logic [63:0] set_index;
      set_index = page % NUM_SETS;
      if (cmd == CMD_PROBE) begin
         for (c = 0; c < NUM_CPUS; c++) begin
            base = (c * NUM_SETS + int'(set_index)) * NUM_WAYS;
            for (w = 0; w < NUM_WAYS; w++) begin
               if (tlb_valid[base + w] && tlb_page[base + w] == page) return 1'b1;
            end
         end
         return 1'b0;
      end
      cpu  = (cpu_raw < NUM_CPUS) ? int'(cpu_raw) : 0;
      base = (cpu * NUM_SETS + int'(set_index)) * NUM_WAYS;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (tlb_valid[base + w] && tlb_page[base + w] == page) begin
            tlb_stamp[base + w] = cpu_tick[cpu];
            cpu_tick[cpu] += 64'd1;
            return 1'b1;
         end
      end
      have_free = 1'b0;
      way = 0;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (!have_free && !tlb_valid[base + w]) begin
            way = w;
            have_free = 1'b1;
         end
      end
      if (!have_free) begin
         n_evict++;
         for (w = 1; w < NUM_WAYS; w++) begin
            if (tlb_stamp[base + w] < tlb_stamp[base + way]) way = w;
         end
      end
      tlb_valid[base + way] = 1'b1;
      tlb_page[base + way]  = page;
      tlb_stamp[base + way] = cpu_tick[cpu];
      cpu_tick[cpu] += 64'd1;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic send_request(input logic cmd, input logic [7:0] cpu_num,
                               input logic [63:0] page);
      pending_type item;
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_cpu_num     <= cpu_num;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      item.cmd     = cmd;
      item.cpu_num = cpu_num;
      item.page    = page;
      item.found   = predict_found(cmd, cpu_num, page);
      pending_found.push_back(item);
      if (cmd == CMD_PROBE) n_probe++;
      else n_access++;
      if (cmd == CMD_ACCESS && cpu_num >= NUM_CPUS) n_foreign_cpu++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_found.size() != 0) @(posedge clock);
   endtask

   // Checks each response against the oldest predicted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_found.size() == 0) begin
            report_mismatch($sformatf("response found=%0b with no request pending", rsp_found));
         end else begin
            oldest = pending_found.pop_front();
            if (rsp_found !== oldest.found) begin
               report_mismatch($sformatf("cmd=%0b cpu=%0d page=%h expected found=%0b got %0b",
                                         oldest.cmd, oldest.cpu_num, oldest.page,
                                         oldest.found, rsp_found));
            end
            if (rsp_found === 1'b1) n_hit++;
         end
      end
   end

   // The receiver stalls at random and takes a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_done != hold_asked) begin
         hold_done  <= hold_asked;
         hold_count <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_cold_probe();
      send_request(CMD_PROBE, 8'd0, 64'd0);
   endtask

   // Out-of-range CPU numbers must land in the TLB of CPU 0.
   task automatic test_cpu_select();
      send_request(CMD_ACCESS, 8'd255, 64'h0000_0000_0000_1234);
      send_request(CMD_ACCESS, 8'd0, 64'h0000_0000_0000_1234);
      send_request(CMD_ACCESS, 8'd4, 64'h0000_0000_0000_1234);
      send_request(CMD_ACCESS, 8'd3, 64'h0000_0000_0000_1234);
      send_request(CMD_ACCESS, 8'd1, 64'h0000_0000_0000_1234);
      send_request(CMD_ACCESS, 8'd2, 64'h0000_0000_0000_1234);
   endtask

   task automatic test_page_extremes();
      send_request(CMD_ACCESS, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(CMD_ACCESS, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(CMD_PROBE, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // Fills one set, refreshes the first way, then forces the oldest way out.
   task automatic test_fill_and_evict();
      int i;
      for (i = 0; i < NUM_WAYS; i++) begin
         send_request(CMD_ACCESS, 8'd2, 64'(i + 1) * NUM_SETS + 64'd5);
      end
      send_request(CMD_ACCESS, 8'd2, 64'd1 * NUM_SETS + 64'd5);
      send_request(CMD_ACCESS, 8'd2, 64'(NUM_WAYS + 1) * NUM_SETS + 64'd5);
      send_request(CMD_PROBE, 8'd0, 64'd2 * NUM_SETS + 64'd5);
      send_request(CMD_ACCESS, 8'd2, 64'd1 * NUM_SETS + 64'd5);
   endtask

   task automatic test_probe_across_cpus();
      send_request(CMD_ACCESS, 8'd3, 64'h8000_0000_0000_01A0);
      send_request(CMD_PROBE, 8'd7, 64'h8000_0000_0000_01A0);
      send_request(CMD_PROBE, 8'd0, 64'h8000_0000_0000_01A0 + NUM_SETS);
   endtask

   // Mostly accesses to a small pool of pages in a few sets, so that hits and
   // evictions are common, with probes and fully random pages mixed in.
   task automatic test_random_traffic(input int count);
      int          i;
      logic        cmd;
      logic [7:0]  cpu_num;
      logic [63:0] page;
      for (i = 0; i < count; i++) begin
         cmd = ($urandom_range(0, 99) < 20) ? CMD_PROBE : CMD_ACCESS;
         if ($urandom_range(0, 4) == 0) cpu_num = 8'($urandom_range(0, 255));
         else cpu_num = 8'($urandom_range(0, NUM_CPUS - 1));
         if ($urandom_range(0, 99) < 85) begin
            page = (hot_tag[$urandom_range(0, 7)] & ~64'(NUM_SETS - 1))
                   | 64'(hot_set[$urandom_range(0, 5)]);
         end else begin
            page = {$urandom, $urandom};
         end
         send_request(cmd, cpu_num, page);
      end
   endtask

   task automatic test_steady_stream();
      no_idle = 1'b1;
      test_random_traffic(100);
      no_idle = 1'b0;
   endtask

   // The receiver holds off while requests keep coming, so the block backs up.
   task automatic test_output_hold_off();
      hold_asked++;
      test_random_traffic(40);
   endtask

   task automatic test_drain_pause();
      test_random_traffic(20);
      wait_drained();
      test_random_traffic(20);
   endtask

   initial begin
      int i;
      foreach (hot_set[i]) hot_set[i] = $urandom_range(0, NUM_SETS - 1);
      foreach (hot_tag[i]) hot_tag[i] = {$urandom, $urandom};
      foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
      foreach (cpu_tick[i]) cpu_tick[i] = 64'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cold_probe();
      test_cpu_select();
      test_page_extremes();
      test_fill_and_evict();
      test_probe_across_cpus();
      test_random_traffic(300);
      test_steady_stream();
      test_output_hold_off();
      test_drain_pause();
      test_random_traffic(180);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (i = 0; i < pending_found.size(); i++) begin
         report_mismatch($sformatf("no response for cmd=%0b cpu=%0d page=%h",
                                   pending_found[i].cmd, pending_found[i].cpu_num,
                                   pending_found[i].page));
      end

      $display("Covered %0d accesses (%0d with out-of-range CPU) and %0d probes.",
               n_access, n_foreign_cpu, n_probe);
      $display("Saw %0d responses with found set and %0d predicted evictions; %0d mismatches.",
               n_hit, n_evict, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
